### rtl/core/bal_pkg.sv
// Shared constants, operation codes and cell command type for the bounded array list.
`default_nettype none

package bal_pkg;

    localparam int DEPTH     = 64;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int CAP_W     = 7;
    localparam int FUNC_W    = 3;
    localparam int POS_W     = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 3'd0,
        FUNC_ERASE  = 3'd1,
        FUNC_READ   = 3'd2,
        FUNC_SCALE  = 3'd3,
        FUNC_ADD    = 3'd4,
        FUNC_CLEAR  = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_SCALE,
        CELL_ADD,
        CELL_LOAD,
        CELL_SHIFT
    } t_cell_op;

    // Broadcast to every cell in the row
    typedef struct packed {
        t_cell_op            op;
        logic [POS_W-1:0]    pos;
        logic [CNT_W-1:0]    count;
        logic [DATA_W-1:0]   value;
        logic [DATA_W-1:0]   scalar;
    } t_cell_cmd;

endpackage

`default_nettype wire

### rtl/core/bal_cell.sv
// One list slot: holds an element and a read tap, exchanges data with its neighbours.
`default_nettype none

module bal_cell
    import bal_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [IDX_W-1:0]  i_index,
    input  wire t_cell_cmd         i_cmd,
    input  wire logic [DATA_W-1:0] i_left_data,
    input  wire logic [DATA_W-1:0] i_right_data,
    input  wire logic [DATA_W-1:0] i_right_tap,
    output logic      [DATA_W-1:0] o_data,
    output logic      [DATA_W-1:0] o_tap
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] r_tap;
    logic [CNT_W-1:0]  w_idx;
    logic [CNT_W-1:0]  w_pos;

    assign w_idx = CNT_W'(i_index);
    assign w_pos = CNT_W'(i_cmd.pos);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CELL_INSERT: begin
                if (w_idx == w_pos) begin
                    r_data <= i_cmd.value;
                end else if (w_idx > w_pos && w_idx <= i_cmd.count) begin
                    r_data <= i_left_data;
                end else if (w_idx >= i_cmd.count && w_idx < w_pos) begin
                    // zero fill the gap of an append
                    r_data <= '0;
                end
            end
            CELL_ERASE: begin
                if (w_idx >= w_pos && (w_idx + CNT_W'(1)) < i_cmd.count) begin
                    r_data <= i_right_data;
                end
            end
            CELL_SCALE: begin
                if (w_idx < i_cmd.count) begin
                    r_data <= DATA_W'(r_data * i_cmd.scalar);
                end
            end
            CELL_ADD: begin
                if (w_idx < i_cmd.count) begin
                    r_data <= DATA_W'(r_data + i_cmd.scalar);
                end
            end
            CELL_LOAD: begin
                r_tap <= r_data;
            end
            CELL_SHIFT: begin
                // advance the tap row one cell towards the head
                r_tap <= i_right_tap;
            end
            default: begin
            end
        endcase
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

`default_nettype wire

### rtl/core/bounded_array_list_unit.sv
// Top level of the bounded array list: control sequencer over a row of list cells.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------------------
//  request   | i_valid / o_ready         | i_func, i_position, i_element_value, i_scalar
//  response  | o_valid / i_ready         | o_ok, o_read_value, o_element_count
//  config    | i_cfg_wr_en (no wait)     | i_cfg_wr_data (capacity)
//
// Insert, erase, scale, add, clear and refused operations load the response register from
// the execute state once the output is free; a read at position p loads the tap row, which
// then moves the element one cell per cycle towards cell 0 before the response is loaded.
// A new request can be taken in the cycle after the previous response is loaded.
// Reset clears the element count and handshake state and sets capacity to 64; element
// contents are not cleared. A stalled response holds and the sequencer waits for it.
`default_nettype none

module bounded_array_list_unit
    import bal_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [CAP_W-1:0]         i_cfg_wr_data,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [FUNC_W-1:0]        i_func,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [DATA_W-1:0] i_element_value,
    input  wire logic [DATA_W-1:0]        i_scalar,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic                          o_ok,
    output logic signed [DATA_W-1:0]      o_read_value,
    output logic [CNT_W-1:0]              o_element_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    t_state             r_state, n_state;
    logic [CAP_W-1:0]   r_capacity;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [POS_W-1:0]   r_cnt, n_cnt;
    logic [FUNC_W-1:0]  r_func;
    logic [POS_W-1:0]   r_pos;
    logic [DATA_W-1:0]  r_value;
    logic [DATA_W-1:0]  r_scalar;
    logic               r_out_valid, n_out_valid;
    logic               r_ok, n_ok;
    logic [DATA_W-1:0]  r_read_value, n_read_value;
    logic [CNT_W-1:0]   r_out_count, n_out_count;

    logic               w_out_free;
    logic               w_ok;
    logic [CNT_W-1:0]   w_cap;
    logic [CNT_W-1:0]   w_pos;
    t_cell_cmd          w_cmd;
    logic [DATA_W-1:0]  w_data [DEPTH];
    logic [DATA_W-1:0]  w_tap  [DEPTH];

    assign w_out_free = !r_out_valid || i_ready;
    assign w_pos      = CNT_W'(r_pos);
    assign w_cap      = (CNT_W'(r_capacity) < CNT_W'(DEPTH)) ? CNT_W'(r_capacity)
                                                              : CNT_W'(DEPTH);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !i_ready;
        n_ok         = r_ok;
        n_read_value = r_read_value;
        n_out_count  = r_out_count;
        w_ok         = 1'b0;
        w_cmd.op     = CELL_HOLD;
        w_cmd.pos    = r_pos;
        w_cmd.count  = r_count;
        w_cmd.value  = r_value;
        w_cmd.scalar = r_scalar;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_func == FUNC_READ && w_pos < r_count) begin
                    w_cmd.op = CELL_LOAD;
                    n_cnt    = r_pos;
                    n_state  = S_READ;
                end else if (w_out_free) begin
                    case (r_func)
                        FUNC_INSERT: begin
                            if (r_count >= w_cap) begin
                                w_ok = 1'b0;
                            end else if (w_pos < r_count) begin
                                w_ok     = 1'b1;
                                w_cmd.op = CELL_INSERT;
                                n_count  = r_count + CNT_W'(1);
                            end else if ((w_pos + CNT_W'(1)) > w_cap) begin
                                w_ok = 1'b0;
                            end else begin
                                w_ok     = 1'b1;
                                w_cmd.op = CELL_INSERT;
                                n_count  = w_pos + CNT_W'(1);
                            end
                        end
                        FUNC_ERASE: begin
                            if (w_pos < r_count) begin
                                w_ok     = 1'b1;
                                w_cmd.op = CELL_ERASE;
                                n_count  = r_count - CNT_W'(1);
                            end
                        end
                        FUNC_SCALE: begin
                            w_ok     = 1'b1;
                            w_cmd.op = CELL_SCALE;
                        end
                        FUNC_ADD: begin
                            w_ok     = 1'b1;
                            w_cmd.op = CELL_ADD;
                        end
                        FUNC_CLEAR: begin
                            w_ok    = 1'b1;
                            n_count = '0;
                        end
                        default: begin
                            w_ok = 1'b0;
                        end
                    endcase
                    n_out_valid  = 1'b1;
                    n_ok         = w_ok;
                    n_read_value = '0;
                    n_out_count  = n_count;
                    n_state      = S_IDLE;
                end
            end
            S_READ: begin
                if (r_cnt == '0) begin
                    if (w_out_free) begin
                        n_out_valid  = 1'b1;
                        n_ok         = 1'b1;
                        n_read_value = w_tap[0];
                        n_out_count  = r_count;
                        n_state      = S_IDLE;
                    end
                end else begin
                    w_cmd.op = CELL_SHIFT;
                    n_cnt    = r_cnt - POS_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
        end
        r_cnt        <= n_cnt;
        r_ok         <= n_ok;
        r_read_value <= n_read_value;
        r_out_count  <= n_out_count;
        // hold the request fields for the whole transaction
        if (r_state == S_IDLE && i_valid) begin
            r_func   <= i_func;
            r_pos    <= i_position;
            r_value  <= i_element_value;
            r_scalar <= i_scalar;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        logic [DATA_W-1:0] w_right_tap;

        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right     = '0;
            assign w_right_tap = '0;
        end else begin : g_body
            assign w_right     = w_data[g+1];
            assign w_right_tap = w_tap[g+1];
        end

        bal_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (IDX_W'(g)),
            .i_cmd        (w_cmd),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .i_right_tap  (w_right_tap),
            .o_data       (w_data[g]),
            .o_tap        (w_tap[g])
        );
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_ok            = r_ok;
    assign o_read_value    = $signed(r_read_value);
    assign o_element_count = r_out_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count above list depth");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while a transaction is in progress");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_read_value == '0))
        else $error("refused transaction carries a read value");

    a_count_only_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EXEC) |=> (r_count == $past(r_count)))
        else $error("element count changed outside execution");
`endif

endmodule

`default_nettype wire
